### rtl/swmm_pkg.sv
package swmm_pkg;

  // sample and result field widths
  localparam int SampleW = 16;
  localparam int CountW  = 7;

  // back end sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ_OLD,
    ST_UPDATE,
    ST_SCAN,
    ST_DIV,
    ST_OUT
  } state_t;

  // word passed from front to back
  typedef struct packed {
    logic [SampleW-1:0] sample;
  } item_t;

endpackage

### rtl/sliding_window_min_max_mean.sv
// channel  | dir | tdata fields (low bit up)
// s_axis   | in  | sample[15:0]
// m_axis   | out | mean_value, min_value, max_value, held_count (pad to 56)
//
// the back end handles each sample in turn: one ring read per cycle for
// the min/max rescan, then one quotient bit per cycle in the serial
// divider.
// rst is synchronous; it clears the queue, count, slot and sum.
// a two word queue lets input be taken while the back end works or stalls.
module sliding_window_min_max_mean #(
  parameter int WINDOW = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // sample
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata   // mean, min, max, held_count, pad
);
  import swmm_pkg::*;

  item_t              in_item;
  item_t              q_item;
  logic               q_valid;
  logic               q_ready;
  logic [SampleW-1:0] mean_value;
  logic [SampleW-1:0] min_value;
  logic [SampleW-1:0] max_value;
  logic [CountW-1:0]  held_count;

  assign in_item.sample = s_axis_tdata;

  swmm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  swmm_back #(.WINDOW(WINDOW)) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_item     (q_item),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .mean_value (mean_value),
    .min_value  (min_value),
    .max_value  (max_value),
    .held_count (held_count)
  );

  assign m_axis_tdata = {1'b0, held_count, max_value, min_value, mean_value};

`ifndef SYNTH
  // min never exceeds max in a result
  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (min_value <= max_value))
    else $error("min above max");

  // mean lies between min and max
  a_mean_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (mean_value >= min_value && mean_value <= max_value))
    else $error("mean out of range");

  // a result covers at least one sample
  a_count: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (held_count != '0 || WINDOW > 127))
    else $error("empty result");
`endif

endmodule

### rtl/swmm_front.sv
module swmm_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  swmm_pkg::item_t  in_item,
  output logic             q_valid,
  input  logic             q_ready,
  output swmm_pkg::item_t  q_item
);
  import swmm_pkg::*;

  // two entry queue between stream input and back end
  item_t      mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] used;
  logic       push;
  logic       pop;

  assign in_ready = (used != 2'd2);
  assign q_valid  = (used != 2'd0);
  assign q_item   = mem[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_item;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      used   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      used <= used + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

### rtl/swmm_back.sv
module swmm_back #(
  parameter int WINDOW = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  output logic                          q_ready,
  input  swmm_pkg::item_t               q_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [swmm_pkg::SampleW-1:0]  mean_value,
  output logic [swmm_pkg::SampleW-1:0]  min_value,
  output logic [swmm_pkg::SampleW-1:0]  max_value,
  output logic [swmm_pkg::CountW-1:0]   held_count
);
  import swmm_pkg::*;

  localparam int AW   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int FW   = $clog2(WINDOW + 1);
  localparam int SumW = SampleW + AW;
  localparam int DW   = $clog2(SumW + 1);
  localparam logic [FW-1:0] FullCount = FW'(WINDOW);
  localparam logic [AW-1:0] LastSlot  = AW'(WINDOW - 1);

  state_t state, state_next;

  // sample ring
  logic [SampleW-1:0] ring [WINDOW];
  logic [SampleW-1:0] rd_data;
  logic [AW-1:0]      rd_addr;
  logic               wr_en;

  logic [AW-1:0]      write_slot;
  logic [FW-1:0]      fill_count;
  logic [SumW-1:0]    running_sum;
  logic [SampleW-1:0] cur;
  logic [FW-1:0]      scan_idx;
  logic               scan_rd;
  logic [SampleW-1:0] lo;
  logic [SampleW-1:0] hi;

  // restoring divider
  logic [SumW-1:0]    quo;
  logic [FW:0]        rem;
  logic [DW-1:0]      div_cnt;
  logic [FW:0]        rem_shift;
  logic               div_ge;

  logic               full;
  assign full = (fill_count == FullCount);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:     if (q_valid) state_next = ST_READ_OLD;
      ST_READ_OLD: state_next = ST_UPDATE;
      ST_UPDATE:   state_next = ST_SCAN;
      ST_SCAN:     if (scan_idx == fill_count && !scan_rd) state_next = ST_DIV;
      ST_DIV:      if (div_cnt == DW'(0)) state_next = ST_OUT;
      ST_OUT:      if (out_ready) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    q_ready   = (state == ST_IDLE);
    out_valid = (state == ST_OUT);
    wr_en     = (state == ST_UPDATE);
    rd_addr   = (state == ST_SCAN) ? scan_idx[AW-1:0] : write_slot;
  end

  // ring read and write ports
  always_ff @(posedge clk) begin
    if (wr_en) ring[write_slot] <= cur;
    rd_data <= ring[rd_addr];
  end

  assign rem_shift = {rem[FW-1:0], quo[SumW-1]};
  assign div_ge    = (rem_shift >= {1'b0, fill_count});

  // state and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      write_slot  <= '0;
      fill_count  <= '0;
      running_sum <= '0;
      scan_rd     <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          if (q_valid) cur <= q_item.sample;
        end
        ST_UPDATE: begin
          // drop the oldest sample when full
          if (full) begin
            running_sum <= running_sum - SumW'(rd_data) + SumW'(cur);
          end else begin
            running_sum <= running_sum + SumW'(cur);
            fill_count  <= fill_count + FW'(1);
          end
          write_slot <= (write_slot == LastSlot) ? '0 : write_slot + AW'(1);
          scan_idx   <= '0;
          scan_rd    <= 1'b0;
          lo         <= '1;
          hi         <= '0;
        end
        ST_SCAN: begin
          // one read issued per cycle, compared in the next cycle
          if (scan_rd) begin
            if (rd_data < lo) lo <= rd_data;
            if (rd_data > hi) hi <= rd_data;
          end
          if (scan_idx != fill_count) begin
            scan_idx <= scan_idx + FW'(1);
            scan_rd  <= 1'b1;
          end else begin
            scan_rd  <= 1'b0;
          end
          quo     <= running_sum;
          rem     <= '0;
          div_cnt <= DW'(SumW);
        end
        ST_DIV: begin
          if (div_cnt != DW'(0)) begin
            rem     <= div_ge ? rem_shift - {1'b0, fill_count} : rem_shift;
            quo     <= {quo[SumW-2:0], div_ge};
            div_cnt <= div_cnt - DW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign mean_value = quo[SampleW-1:0];
  assign min_value  = lo;
  assign max_value  = hi;
  assign held_count = CountW'(fill_count);

endmodule
